// ----- hw/rtl/bol_pkg.sv -----
// shared types and constants for the bounded ordered list
// no dependencies; imported by bol_slots and bounded_ordered_list
package bol_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int WORD_W     = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_TAIL = 3'd0,
    REQ_PUSH_HEAD = 3'd1,
    REQ_POP_TAIL  = 3'd2,
    REQ_POP_HEAD  = 3'd3,
    REQ_INSERT    = 3'd4,
    REQ_ERASE     = 3'd5,
    REQ_READ      = 3'd6,
    REQ_CLEAR     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // one update of the slot row
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] word;
  } slot_op_t;

endpackage

// ----- hw/rtl/bol_slots.sv -----
// row of list slots with single-step shift on insert and erase
// depends on bol_pkg
module bol_slots
  import bol_pkg::*;
(
  input  logic                  clk,
  input  slot_op_t              op,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [DATA_WIDTH-1:0] rd_word
);

  logic [DATA_WIDTH-1:0] slot      [DEPTH];
  logic [DATA_WIDTH-1:0] slot_next [DEPTH];

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      slot_next[k] = slot[k];
      if (op.ins && IDX_W'(k) == op.idx) begin
        slot_next[k] = op.word;
      end
    end
    // insert moves the slots behind the gap one place back
    for (int k = 1; k < DEPTH; k++) begin
      if (op.ins && IDX_W'(k) > op.idx) begin
        slot_next[k] = slot[k-1];
      end
    end
    // last slot keeps its word, it lies beyond the new count anyway
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (op.del && !op.ins && IDX_W'(k) >= op.idx) begin
        slot_next[k] = slot[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      slot[k] <= slot_next[k];
    end
  end

  assign rd_word = slot[rd_idx];

endmodule

// ----- hw/rtl/bounded_ordered_list.sv -----
// Ordered list of up to DEPTH words with 1-based positions, fed one request
// per transaction (push/pop at either end, insert, erase, read, clear). Each
// request is decided and applied in the cycle it is accepted and its result
// is held in an output register; one request per clock is sustained, the
// only limit being the single result register, which frees as it is taken.
// Slots beyond the count hold stale data and are never returned.
// depends on bol_pkg and bol_slots
module bounded_ordered_list
  import bol_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // position[4:0], value[36:5], zero pad
  input  logic [2:0]  s_tuser,  // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // read_data[31:0], status[33:32], entry_count[38:34], pad
);

  logic                  accept;
  req_t                  req;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] word;

  logic [CNT_W-1:0]      count, count_next;
  logic [DATA_WIDTH-1:0] read_data, read_data_next;
  status_t               status, status_next;
  logic                  want_data;
  slot_op_t              op;
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] rd_word;
  logic                  full, empty;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign req      = req_t'(s_tuser);
  assign position = s_tdata[POS_W-1:0];
  assign word     = s_tdata[POS_W +: DATA_WIDTH];

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    op          = '0;
    op.word     = word;
    rd_idx      = '0;
    want_data   = 1'b0;
    status_next = ST_OK;
    count_next  = count;
    case (req)
      REQ_PUSH_TAIL, REQ_PUSH_HEAD: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op.ins     = 1'b1;
          op.idx     = (req == REQ_PUSH_TAIL) ? count[IDX_W-1:0] : '0;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_POP_TAIL, REQ_POP_HEAD: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          op.del     = 1'b1;
          op.idx     = (req == REQ_POP_TAIL) ? IDX_W'(count - CNT_W'(1)) : '0;
          rd_idx     = op.idx;
          want_data  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (empty) begin
          op.ins     = 1'b1;
          count_next = CNT_W'(1);
        end else if (position == '0 || position > POS_W'(count) + POS_W'(1)) begin
          status_next = ST_BADPOS;
        end else begin
          op.ins     = 1'b1;
          op.idx     = IDX_W'(position - POS_W'(1));
          count_next = count + CNT_W'(1);
        end
      end
      REQ_ERASE, REQ_READ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (position == '0 || position > POS_W'(count)) begin
          status_next = ST_BADPOS;
        end else if (req == REQ_ERASE) begin
          op.del     = 1'b1;
          op.idx     = IDX_W'(position - POS_W'(1));
          count_next = count - CNT_W'(1);
        end else begin
          rd_idx    = IDX_W'(position - POS_W'(1));
          want_data = 1'b1;
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    read_data_next = want_data ? rd_word : '0;
    // nothing changes unless the request is actually taken
    if (!accept) begin
      op.ins = 1'b0;
      op.del = 1'b0;
    end
  end

  bol_slots u_slots (
    .clk     (clk),
    .op      (op),
    .rd_idx  (rd_idx),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= read_data_next;
      status    <= status_next;
    end
  end

  assign m_tdata = {1'b0, POS_W'(count), status, WORD_W'(read_data)};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req == REQ_CLEAR |=> count == '0 && status == ST_OK)
    else $error("clear left entries");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_FULL |-> count == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_OK |-> read_data == '0)
    else $error("failed request returned data");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(count))
    else $error("list changed while result stalled");
`endif

endmodule
